>>> rtl/ipsc_pkg.sv
// Package for the incremental PID speed controller.
// Holds widths, fixed-point constants, register indexes, the sequencer states and the
// divider result type. It has no dependencies.
package ipsc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int GAIN_W     = 32;
    localparam int TS_W       = 16;
    localparam int RPM_W      = 16;
    localparam int ERR_W      = 17;
    localparam int OUT_W      = 23;
    localparam int DUTY_W     = 16;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int ACC_W  = 57;
    localparam int ILO_W  = 48;
    localparam int ISUM_W = 64;
    localparam int ET_W   = 33;
    localparam int QUOT_W = 54;
    localparam int REM_W  = 10;
    localparam int PART_W = REM_W + 4;
    localparam int DIV_STEPS = ISUM_W / 4;

    localparam int MS_PER_S = 1000;
    localparam logic [PART_W-1:0] C_MS_PER_S = PART_W'(MS_PER_S);

    localparam logic [OUT_W-1:0]  C_U_MAX      = 23'd6553600;
    localparam logic [23:0]       C_DUTY_RECIP = 24'd10737419;
    localparam int                DUTY_SHIFT   = 30;
    localparam logic [TS_W-1:0]   C_TS_RESET   = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN,
        CFG_INTEG_GAIN,
        CFG_DERIV_GAIN,
        CFG_SAMPLE_PERIOD
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_D,
        S_MUL_ET,
        S_MUL_ILO,
        S_MUL_IHI,
        S_ISUM,
        S_DSTART,
        S_IDIV,
        S_IADD,
        S_CLAMP,
        S_SCALE,
        S_MUL_DUTY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              done;
        logic              neg;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

    function automatic logic [PART_W-1:0] div_multiple(input logic [3:0] k);
        return PART_W'(int'(k) * MS_PER_S);
    endfunction

endpackage

>>> rtl/ipsc_in_if.sv
// Input channel of the speed controller: one speed sample per transaction.
// Carries valid, ready and the sample fields; it has no dependencies.
interface ipsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] measured_rpm;
    logic [15:0] target_rpm;
    logic        shutdown_req;

    modport source (output valid, output measured_rpm, output target_rpm,
                    output shutdown_req, input ready);
    modport sink   (input valid, input measured_rpm, input target_rpm,
                    input shutdown_req, output ready);
endinterface

>>> rtl/ipsc_out_if.sv
// Output channel of the speed controller: one PWM duty per transaction.
// Carries valid, ready and the duty; it has no dependencies.
interface ipsc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty_out;

    modport source (output valid, output duty_out, input ready);
    modport sink   (input valid, input duty_out, output ready);
endinterface

>>> rtl/ipsc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ipsc_pkg for the operand widths.
module ipsc_mul import ipsc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_prod
);

    logic signed [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/ipsc_div.sv
// Radix-16 long divider by the constant 1000, truncating toward zero.
// One quotient digit per cycle; depends on ipsc_pkg.
module ipsc_div import ipsc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ISUM_W-1:0] i_num,
    output t_div_res                 o_res
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [ISUM_W-1:0] r_num;
    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;

    logic [PART_W-1:0] w_part;
    logic [PART_W-1:0] w_diff;
    logic [3:0]        w_digit;

    always_comb begin
        w_part  = {r_rem, r_num[ISUM_W-1 -: 4]};
        w_digit = '0;
        for (int k = 1; k < 16; k++) begin
            if (w_part >= div_multiple(4'(k))) begin
                w_digit = 4'(k);
            end
        end
        w_diff = w_part - div_multiple(w_digit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_num[ISUM_W-1];
            r_num  <= i_num[ISUM_W-1] ? ISUM_W'(-i_num) : ISUM_W'(i_num);
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[ISUM_W-5:0], 4'b0000};
            r_rem  <= w_diff[REM_W-1:0];
            r_quot <= {r_quot[QUOT_W-5:0], w_digit};
        end
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;
    assign o_res.quot = r_quot;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ({4'b0000, r_rem} < C_MS_PER_S))
        else $error("Divider remainder reached the divisor.");

    a_no_restart_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("Divider started while a division was in progress.");

    a_done_after_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("Divider completion without a preceding division.");

endmodule

>>> rtl/incremental_pid_speed_controller.sv
// Incremental PID speed controller: one sample in, one 16-bit PWM duty out.
// A sample is accepted only in the idle state, so the next one waits until the previous duty
// has been loaded for output, after the shared multiplier sequence and the divider.
// A waiting duty holds the sequencer in its final step until it is taken.
// Synchronous active-low reset restores the register defaults and clears all history.
module incremental_pid_speed_controller import ipsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ipsc_in_if.sink               i_sample,
    ipsc_out_if.source            o_result
);

    t_state r_state;
    t_state n_state;

    logic signed [GAIN_W-1:0] r_kp;
    logic signed [GAIN_W-1:0] r_ki;
    logic signed [GAIN_W-1:0] r_kd;
    logic [TS_W-1:0]          r_ts;

    logic signed [ERR_W-1:0]   r_e;
    logic signed [ERR_W-1:0]   r_e1;
    logic signed [ERR_W-1:0]   r_e2;
    logic signed [ERR_W:0]     r_dp;
    logic signed [ERR_W+1:0]   r_dd;
    logic                      r_shut;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [ET_W-1:0]    r_et;
    logic signed [ILO_W-1:0]   r_ilo;
    logic signed [ISUM_W-1:0]  r_isum;
    logic [OUT_W-1:0]          r_u;
    logic [OUT_W-1:0]          r_u1;
    logic [OUT_W-1:0]          r_v;
    logic                      r_out_valid;
    logic [DUTY_W-1:0]         r_duty;

    logic signed [ERR_W-1:0]   w_e;
    logic signed [ERR_W:0]     w_dp;
    logic signed [ERR_W+1:0]   w_dd;
    logic                      w_accept;
    logic                      w_in_ready;
    logic                      w_out_load;
    logic                      w_mul_en;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic                      w_div_start;
    t_div_res                  w_div;
    logic [OUT_W-1:0]          w_clamped;
    logic [OUT_W+15:0]         w_scaled;

    ipsc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    ipsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_isum),
        .o_res   (w_div)
    );

    always_comb begin
        w_e  = $signed({1'b0, i_sample.target_rpm}) - $signed({1'b0, i_sample.measured_rpm});
        w_dp = $signed({w_e[ERR_W-1], w_e}) - $signed({r_e1[ERR_W-1], r_e1});
        w_dd = $signed({{2{w_e[ERR_W-1]}}, w_e}) - $signed({r_e1[ERR_W-1], r_e1, 1'b0})
             + $signed({{2{r_e2[ERR_W-1]}}, r_e2});
    end

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            w_clamped = '0;
        end else if (r_acc > $signed({{(ACC_W-OUT_W){1'b0}}, C_U_MAX})) begin
            w_clamped = C_U_MAX;
        end else begin
            w_clamped = r_acc[OUT_W-1:0];
        end
        w_scaled = {r_u, 16'h0000} - {16'h0000, r_u};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_sample.valid) n_state = S_MUL_P;
            S_MUL_P:    n_state = S_MUL_D;
            S_MUL_D:    n_state = S_MUL_ET;
            S_MUL_ET:   n_state = S_MUL_ILO;
            S_MUL_ILO:  n_state = S_MUL_IHI;
            S_MUL_IHI:  n_state = S_ISUM;
            S_ISUM:     n_state = S_DSTART;
            S_DSTART:   n_state = S_IDIV;
            S_IDIV:     if (w_div.done) n_state = S_IADD;
            S_IADD:     n_state = S_CLAMP;
            S_CLAMP:    n_state = S_SCALE;
            S_SCALE:    n_state = S_MUL_DUTY;
            S_MUL_DUTY: n_state = S_OUT;
            S_OUT:      if (!r_out_valid || o_result.ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_out_load  = 1'b0;
        w_div_start = 1'b0;
        w_mul_en    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_MUL_P: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_kp);
                w_mul_b  = MUL_B_W'(r_dp);
            end
            S_MUL_D: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_kd);
                w_mul_b  = MUL_B_W'(r_dd);
            end
            S_MUL_ET: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_e);
                w_mul_b  = $signed({{(MUL_B_W-TS_W){1'b0}}, r_ts});
            end
            S_MUL_ILO: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_ki);
                w_mul_b  = $signed({{(MUL_B_W-16){1'b0}}, w_prod[15:0]});
            end
            S_MUL_IHI: begin
                w_mul_en = 1'b1;
                w_mul_a  = MUL_A_W'(r_ki);
                w_mul_b  = MUL_B_W'($signed(r_et[ET_W-1:16]));
            end
            S_DSTART: begin
                w_div_start = 1'b1;
            end
            S_MUL_DUTY: begin
                w_mul_en = 1'b1;
                w_mul_a  = $signed({{(MUL_A_W-OUT_W){1'b0}}, r_v});
                w_mul_b  = $signed({1'b0, C_DUTY_RECIP});
            end
            S_OUT: begin
                w_out_load = !r_out_valid || o_result.ready;
            end
            S_ISUM, S_IDIV, S_IADD, S_CLAMP, S_SCALE: begin
            end
            default: begin
            end
        endcase
    end

    assign w_accept = w_in_ready && i_sample.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_ts        <= C_TS_RESET;
            r_e1        <= '0;
            r_e2        <= '0;
            r_u1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_PROP_GAIN:     r_kp <= $signed(i_cfg_data[GAIN_W-1:0]);
                    CFG_INTEG_GAIN:    r_ki <= $signed(i_cfg_data[GAIN_W-1:0]);
                    CFG_DERIV_GAIN:    r_kd <= $signed(i_cfg_data[GAIN_W-1:0]);
                    CFG_SAMPLE_PERIOD: r_ts <= i_cfg_data[TS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_e1 <= w_e;
                r_e2 <= r_e1;
            end
            if (r_state == S_CLAMP) begin
                r_u1 <= r_shut ? '0 : w_clamped;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e    <= w_e;
            r_dp   <= w_dp;
            r_dd   <= w_dd;
            r_shut <= i_sample.shutdown_req;
            r_acc  <= $signed({{(ACC_W-OUT_W){1'b0}}, r_u1});
        end
        unique case (r_state)
            S_MUL_D, S_MUL_ET: begin
                r_acc <= r_acc + $signed(w_prod[ACC_W-1:0]);
            end
            S_MUL_ILO: begin
                r_et <= w_prod[ET_W-1:0];
            end
            S_MUL_IHI: begin
                r_ilo <= w_prod[ILO_W-1:0];
            end
            S_ISUM: begin
                r_isum <= $signed({w_prod[ILO_W-1:0], 16'h0000})
                        + $signed({{(ISUM_W-ILO_W){r_ilo[ILO_W-1]}}, r_ilo});
            end
            S_IADD: begin
                if (w_div.neg) begin
                    r_acc <= r_acc - $signed({{(ACC_W-QUOT_W){1'b0}}, w_div.quot});
                end else begin
                    r_acc <= r_acc + $signed({{(ACC_W-QUOT_W){1'b0}}, w_div.quot});
                end
            end
            S_CLAMP: begin
                r_u <= w_clamped;
            end
            S_SCALE: begin
                r_v <= w_scaled[OUT_W+15:16];
            end
            S_OUT: begin
                if (w_out_load) begin
                    r_duty <= r_shut ? '0 : w_prod[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
                end
            end
            S_IDLE, S_MUL_P, S_DSTART, S_IDIV, S_MUL_DUTY: begin
            end
            default: begin
            end
        endcase
    end

    assign i_sample.ready    = w_in_ready;
    assign o_result.valid    = r_out_valid;
    assign o_result.duty_out = r_duty;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_sample.ready)
        else $error("Sample accepted while the previous sample is still in progress.");

    a_history_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u1 <= C_U_MAX)
        else $error("Stored output exceeds full scale.");

    a_shutdown_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_shut) |=> (o_result.valid && o_result.duty_out == '0))
        else $error("Shutdown sample produced a non-zero duty.");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_IDIV))
        else $error("Divider finished outside the wait state.");

endmodule
